@@ design/pobp_pkg.sv @@
// Shared types and constants for the pass order and barrier planner.
`timescale 1ns / 1ps

package pobp_pkg;

    localparam int MASK_W   = 8;
    localparam int FROM_W   = 24;
    localparam int STATE_W  = 3;
    localparam int KIND_W   = 2;
    localparam int PIDX_W   = 3;
    localparam int STATUS_W = 2;
    localparam int KINDS_W  = 16;

    // Tracked resource states
    localparam logic [STATE_W-1:0] ST_UNDEFINED    = 3'd0;
    localparam logic [STATE_W-1:0] ST_COLOR_TARGET = 3'd1;
    localparam logic [STATE_W-1:0] ST_DEPTH_WRITE  = 3'd2;
    localparam logic [STATE_W-1:0] ST_SHADER_READ  = 3'd4;
    localparam logic [STATE_W-1:0] ST_PRESENT      = 3'd5;

    // Resource kinds
    localparam logic [KIND_W-1:0] KIND_TRANSIENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHADOW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWAPCHAIN = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CYCLE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [MASK_W-1:0] read_mask;
        logic [MASK_W-1:0] write_mask;
        logic              last_pass;
    } pass_in_t;

    typedef struct packed {
        logic [PIDX_W-1:0]   pass_index;
        logic [MASK_W-1:0]   read_barrier_mask;
        logic [FROM_W-1:0]   read_from_states;
        logic [MASK_W-1:0]   write_barrier_mask;
        logic [FROM_W-1:0]   write_from_states;
        logic [MASK_W-1:0]   present_mask;
        logic [STATUS_W-1:0] status;
        logic                last_result;
    } pass_out_t;

    typedef struct packed {
        logic                load;
        logic                frame_end;
        logic                solve_start;
        logic                order_step;
        logic                emit_begin;
        logic                emit_step;
        logic                emit_err;
        logic [STATUS_W-1:0] err_code;
    } pobp_cmd_t;

    typedef struct packed {
        logic full;
        logic found;
        logic last_step;
        logic out_free;
    } pobp_status_t;

endpackage

@@ design/pobp_ctrl.sv @@
// Controller state machine: load, order, emit and error phases.
`timescale 1ns / 1ps

module pobp_ctrl import pobp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_last,
    output logic         s_ready,
    input  pobp_status_t status,
    output pobp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ORDER,
        S_EMIT,
        S_ERROR
    } state_t;

    state_t              state_reg;
    logic                ovf_reg;
    logic [STATUS_W-1:0] err_code_reg;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = !status.full;
                    if (s_last) begin
                        cmd.frame_end   = 1'b1;
                        cmd.solve_start = !(ovf_reg || status.full);
                    end
                end
            end
            S_ORDER: begin
                if (status.found) begin
                    cmd.order_step = 1'b1;
                    cmd.emit_begin = status.last_step;
                end
            end
            S_EMIT: begin
                cmd.emit_step = status.out_free;
            end
            S_ERROR: begin
                cmd.emit_err = status.out_free;
                cmd.err_code = err_code_reg;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ovf_reg      <= 1'b0;
            err_code_reg <= STATUS_OK;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_last) begin
                            ovf_reg <= 1'b0;
                            if (ovf_reg || status.full) begin
                                state_reg    <= S_ERROR;
                                err_code_reg <= STATUS_OVERFLOW;
                            end else begin
                                state_reg <= S_ORDER;
                            end
                        end else if (status.full) begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                S_ORDER: begin
                    // No ready pass left: the graph has a cycle
                    if (!status.found) begin
                        state_reg    <= S_ERROR;
                        err_code_reg <= STATUS_CYCLE;
                    end else if (status.last_step) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (status.out_free && status.last_step) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_ERROR: begin
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("planner idle straight after final pass");

    a_order_not_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ORDER) |=> (state_reg != S_IDLE))
        else $error("ordering phase ended without results");

    a_solve_stores_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.solve_start |-> cmd.load)
        else $error("solve started without storing the final pass");
`endif

endmodule

@@ design/pobp_datapath.sv @@
// Datapath: pass tables, dependency matrix, ordering, barrier planning, output register.
`timescale 1ns / 1ps

module pobp_datapath import pobp_pkg::*; #(
    parameter int MAX_PASSES    = 8,
    parameter int MAX_RESOURCES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pobp_cmd_t          cmd,
    output pobp_status_t       status,
    input  pass_in_t           s_data,
    input  logic               cfg_wr_en,
    input  logic [KINDS_W-1:0] cfg_wr_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pass_out_t          m_data
);

    localparam int RES_W = (MAX_RESOURCES < MASK_W) ? MAX_RESOURCES : MASK_W;
    localparam int IDX_W = $clog2(MAX_PASSES);
    localparam int CNT_W = $clog2(MAX_PASSES + 1);

    logic [RES_W-1:0]      reads_reg  [MAX_PASSES];
    logic [RES_W-1:0]      writes_reg [MAX_PASSES];
    logic [MAX_PASSES-1:0] dep_reg    [MAX_PASSES];
    logic [IDX_W-1:0]      order_reg  [MAX_PASSES];
    logic [STATE_W-1:0]    track_reg  [RES_W];
    logic [STATE_W-1:0]    track_next [RES_W];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      step_reg;
    logic [MAX_PASSES-1:0] fin_reg;
    logic [KINDS_W-1:0]    kinds_reg;
    logic                  m_valid_reg;
    pass_out_t             out_reg;

    logic [RES_W-1:0]      rd_in;
    logic [RES_W-1:0]      wr_in;
    logic [IDX_W-1:0]      load_idx;
    logic [IDX_W-1:0]      step_idx;
    logic [MAX_PASSES-1:0] valid_vec;
    logic [MAX_PASSES-1:0] ready_vec;
    logic [IDX_W-1:0]      sel_idx;
    logic [IDX_W-1:0]      cur_pass;
    logic [RES_W-1:0]      cur_rd;
    logic [RES_W-1:0]      cur_wr;
    logic [RES_W-1:0]      rmask;
    logic [RES_W-1:0]      wmask;
    logic [RES_W-1:0]      pmask;
    logic [STATE_W*RES_W-1:0] rfrom;
    logic [STATE_W*RES_W-1:0] wfrom;
    pass_out_t             plan_out;
    pass_out_t             err_out;

    assign rd_in    = s_data.read_mask[RES_W-1:0];
    assign wr_in    = s_data.write_mask[RES_W-1:0];
    assign load_idx = count_reg[IDX_W-1:0];
    assign step_idx = step_reg[IDX_W-1:0];

    // Ready: not finished, and every producer of its reads is finished
    always_comb begin
        logic [MAX_PASSES-1:0] self_bit;
        for (int c = 0; c < MAX_PASSES; c++) begin
            self_bit     = '0;
            self_bit[c]  = 1'b1;
            valid_vec[c] = (CNT_W'(c) < n_reg);
            ready_vec[c] = 1'b0;
        end
        for (int c = 0; c < MAX_PASSES; c++) begin
            self_bit    = '0;
            self_bit[c] = 1'b1;
            ready_vec[c] = valid_vec[c] && !fin_reg[c]
                && ((dep_reg[c] & valid_vec & ~fin_reg & ~self_bit) == '0);
        end
    end

    // Lowest ready index wins
    always_comb begin
        sel_idx = '0;
        for (int c = MAX_PASSES - 1; c >= 0; c--) begin
            if (ready_vec[c]) begin
                sel_idx = IDX_W'(c);
            end
        end
    end

    assign status.full      = (count_reg == CNT_W'(MAX_PASSES));
    assign status.found     = |ready_vec;
    assign status.last_step = (step_reg == n_reg - CNT_W'(1));
    assign status.out_free  = !m_valid_reg || m_ready;

    assign cur_pass = order_reg[step_idx];
    assign cur_rd   = reads_reg[cur_pass];
    assign cur_wr   = writes_reg[cur_pass];

    // Per-resource barrier lanes: read, then write, then present
    always_comb begin
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] st0;
        logic [STATE_W-1:0] st1;
        logic [STATE_W-1:0] st2;
        logic [STATE_W-1:0] wto;
        for (int r = 0; r < RES_W; r++) begin
            kind = kinds_reg[2*r +: KIND_W];
            st0  = track_reg[r];
            rmask[r] = cur_rd[r] && (kind != KIND_TRANSIENT) && (st0 != ST_SHADER_READ);
            rfrom[STATE_W*r +: STATE_W] = rmask[r] ? st0 : ST_UNDEFINED;
            st1  = rmask[r] ? ST_SHADER_READ : st0;
            wto  = (kind == KIND_SHADOW) ? ST_DEPTH_WRITE : ST_COLOR_TARGET;
            wmask[r] = cur_wr[r] && (kind != KIND_TRANSIENT) && (st1 != wto);
            wfrom[STATE_W*r +: STATE_W] = wmask[r] ? st1 : ST_UNDEFINED;
            st2  = wmask[r] ? wto : st1;
            pmask[r] = cur_wr[r] && (kind == KIND_SWAPCHAIN) && (st2 != ST_PRESENT);
            track_next[r] = pmask[r] ? ST_PRESENT : st2;
        end
    end

    always_comb begin
        plan_out                    = '0;
        plan_out.pass_index         = PIDX_W'(cur_pass);
        plan_out.read_barrier_mask  = MASK_W'(rmask);
        plan_out.read_from_states   = FROM_W'(rfrom);
        plan_out.write_barrier_mask = MASK_W'(wmask);
        plan_out.write_from_states  = FROM_W'(wfrom);
        plan_out.present_mask       = MASK_W'(pmask);
        plan_out.status             = STATUS_OK;
        plan_out.last_result        = status.last_step;
    end

    // Error transfer: status code only, marked final
    always_comb begin
        err_out             = '0;
        err_out.status      = cmd.err_code;
        err_out.last_result = 1'b1;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            n_reg       <= '0;
            step_reg    <= '0;
            fin_reg     <= '0;
            kinds_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                kinds_reg <= cfg_wr_data;
            end
            if (cmd.frame_end) begin
                count_reg <= '0;
            end else if (cmd.load) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.solve_start) begin
                n_reg    <= count_reg + CNT_W'(1);
                step_reg <= '0;
                fin_reg  <= '0;
            end else if (cmd.emit_begin) begin
                step_reg <= '0;
            end else if (cmd.order_step || cmd.emit_step) begin
                step_reg <= step_reg + CNT_W'(1);
            end
            if (cmd.order_step) begin
                fin_reg[sel_idx] <= 1'b1;
            end
            if (cmd.emit_step || cmd.emit_err) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            reads_reg[load_idx]  <= rd_in;
            writes_reg[load_idx] <= wr_in;
            for (int c = 0; c < MAX_PASSES; c++) begin
                for (int p = 0; p < MAX_PASSES; p++) begin
                    if ((IDX_W'(c) == load_idx) && (IDX_W'(p) < load_idx)) begin
                        dep_reg[c][p] <= |(writes_reg[p] & rd_in);
                    end else if ((IDX_W'(p) == load_idx) && (IDX_W'(c) < load_idx)) begin
                        dep_reg[c][p] <= |(wr_in & reads_reg[c]);
                    end
                end
            end
        end
        if (cmd.order_step) begin
            order_reg[step_idx] <= sel_idx;
        end
        if (cmd.emit_begin) begin
            for (int r = 0; r < RES_W; r++) begin
                track_reg[r] <= ST_UNDEFINED;
            end
        end else if (cmd.emit_step) begin
            for (int r = 0; r < RES_W; r++) begin
                track_reg[r] <= track_next[r];
            end
        end
        if (cmd.emit_step) begin
            out_reg <= plan_out;
        end else if (cmd.emit_err) begin
            out_reg <= err_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_order_adds_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.order_step |=> ($countones(fin_reg) == $past($countones(fin_reg)) + 1))
        else $error("ordering step did not retire exactly one pass");

    a_error_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != STATUS_OK)) |-> m_data.last_result)
        else $error("error result not marked final");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_step |-> (step_reg < n_reg))
        else $error("emit step beyond pass count");
`endif

endmodule

@@ design/pass_order_and_barrier_planner_core.sv @@
// Top level of the pass order and barrier planner: controller plus datapath.
// Loading: one pass per cycle, s_ready high only while idle, not during a solve or error.
// Solve of n passes: ordering retires one pass per cycle from the ready scan,
// then one result per cycle whenever the output register is free.
// Error results (cycle or too many passes) go out once the output register is free.
// Reset (aresetn, synchronous, active low) clears control and kinds; pass tables need loading.
`timescale 1ns / 1ps

module pass_order_and_barrier_planner_core import pobp_pkg::*; #(
    parameter int MAX_PASSES    = 8,
    parameter int MAX_RESOURCES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pass_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pass_out_t          m_data,
    input  logic               cfg_wr_en,
    input  logic [KINDS_W-1:0] cfg_wr_data
);

    pobp_cmd_t    cmd;
    pobp_status_t status;

    pobp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_pass),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pobp_datapath #(
        .MAX_PASSES    (MAX_PASSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the pass order and barrier planner: frame stimulus and checker.
`timescale 1ns / 1ps

module tb_top;
    import pobp_pkg::*;

    localparam int MAX_P        = 8;
    localparam int MAX_R        = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 22;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    pass_in_t           s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    pass_out_t          m_data;
    logic               cfg_wr_en   = 1'b0;
    logic [KINDS_W-1:0] cfg_wr_data = '0;

    pass_in_t  pass_queue[$];
    pass_out_t planned_results[$];

    // planner model state
    logic [KINDS_W-1:0] kinds_model = '0;
    logic [MASK_W-1:0]  frame_reads  [MAX_P];
    logic [MASK_W-1:0]  frame_writes [MAX_P];
    int                 frame_count  = 0;
    bit                 frame_over   = 1'b0;
    logic [STATE_W-1:0] res_state    [MAX_R];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    bit hold_off       = 1'b0;
    bit in_taken       = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned fail_count     = 0;
    int unsigned passes_taken   = 0;
    int unsigned frames_solved  = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_errors   = 0;
    int unsigned overflow_errs  = 0;

    pass_order_and_barrier_planner_core #(
        .MAX_PASSES    (MAX_P),
        .MAX_RESOURCES (MAX_R)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic void push_error(input logic [STATUS_W-1:0] code);
        pass_out_t res;
        res             = '0;
        res.status      = code;
        res.last_result = 1'b1;
        planned_results.insert(planned_results.size(), res);
        if (code == STATUS_CYCLE) cycle_errors++;
        else overflow_errs++;
    endfunction

    // Move resource r towards a state; report the prior state when a barrier is needed.
    function automatic bit move_state(input int r, input logic [STATE_W-1:0] to,
                                      output logic [STATE_W-1:0] prior);
        prior = res_state[r];
        if (kinds_model[2*r +: 2] == KIND_TRANSIENT) return 1'b0;
        if (to == ST_UNDEFINED || res_state[r] == to) return 1'b0;
        res_state[r] = to;
        return 1'b1;
    endfunction

    function automatic void plan_frame();
        int                 n;
        int unsigned        deg   [MAX_P];
        int                 order [MAX_P];
        logic [MAX_P-1:0]   done;
        logic [STATE_W-1:0] prior;
        logic [STATE_W-1:0] wr_state;
        int                 pick;
        int                 pi;
        pass_out_t          res;
        n = frame_count;
        for (int c = 0; c < n; c++) begin
            deg[c] = 0;
            for (int r = 0; r < MAX_R; r++)
                if (frame_reads[c][r])
                    for (int p = 0; p < n; p++)
                        if (p != c && frame_writes[p][r]) deg[c]++;
        end
        done = '0;
        for (int step = 0; step < n; step++) begin
            pick = n;
            for (int p = 0; p < n; p++)
                if (!done[p] && deg[p] == 0) begin
                    pick = p;
                    break;
                end
            if (pick == n) begin
                push_error(STATUS_CYCLE);
                return;
            end
            done[pick]  = 1'b1;
            order[step] = pick;
            for (int c = 0; c < n; c++) begin
                if (c == pick) continue;
                for (int r = 0; r < MAX_R; r++)
                    if (frame_writes[pick][r] && frame_reads[c][r] && deg[c] > 0) deg[c]--;
            end
        end
        for (int r = 0; r < MAX_R; r++) res_state[r] = ST_UNDEFINED;
        for (int step = 0; step < n; step++) begin
            pi             = order[step];
            res            = '0;
            res.pass_index = pi[PIDX_W-1:0];
            for (int r = 0; r < MAX_R; r++)
                if (frame_reads[pi][r] && move_state(r, ST_SHADER_READ, prior)) begin
                    res.read_barrier_mask[r]       = 1'b1;
                    res.read_from_states[3*r +: 3] = prior;
                end
            for (int r = 0; r < MAX_R; r++) begin
                wr_state = (kinds_model[2*r +: 2] == KIND_SHADOW) ? ST_DEPTH_WRITE
                                                                : ST_COLOR_TARGET;
                if (frame_writes[pi][r] && move_state(r, wr_state, prior)) begin
                    res.write_barrier_mask[r]       = 1'b1;
                    res.write_from_states[3*r +: 3] = prior;
                end
            end
            for (int r = 0; r < MAX_R; r++)
                if (frame_writes[pi][r] && kinds_model[2*r +: 2] == KIND_SWAPCHAIN
                    && move_state(r, ST_PRESENT, prior))
                    res.present_mask[r] = 1'b1;
            res.status      = STATUS_OK;
            res.last_result = (step == n - 1);
            planned_results.insert(planned_results.size(), res);
        end
    endfunction

    function automatic void record_pass(input pass_in_t item);
        if (frame_count < MAX_P) begin
            frame_reads[frame_count]  = item.read_mask;
            frame_writes[frame_count] = item.write_mask;
            frame_count++;
        end else begin
            frame_over = 1'b1;
        end
        if (item.last_pass) begin
            if (frame_over) push_error(STATUS_OVERFLOW);
            else plan_frame();
            frame_count = 0;
            frame_over  = 1'b0;
            frames_solved++;
        end
    endfunction

    function automatic void note_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    function automatic void check_result(input pass_out_t got);
        pass_out_t want;
        results_seen++;
        if (planned_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, got);
            return;
        end
        want = planned_results.pop_front();
        note_mismatch("pass_index", 32'(want.pass_index), 32'(got.pass_index));
        note_mismatch("read_barrier_mask", 32'(want.read_barrier_mask),
                      32'(got.read_barrier_mask));
        note_mismatch("read_from_states", 32'(want.read_from_states),
                      32'(got.read_from_states));
        note_mismatch("write_barrier_mask", 32'(want.write_barrier_mask),
                      32'(got.write_barrier_mask));
        note_mismatch("write_from_states", 32'(want.write_from_states),
                      32'(got.write_from_states));
        note_mismatch("present_mask", 32'(want.present_mask), 32'(got.present_mask));
        note_mismatch("status", 32'(want.status), 32'(got.status));
        note_mismatch("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction

    // ------------------------------------------------------- driver/monitor

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pass_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pass_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                passes_taken++;
                record_pass(s_data);
            end
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    // long receiver hold-off so the block fills and back-pressures its input
    initial begin
        wait (hold_request);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, planned_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------- stimulus

    function automatic void queue_pass(input logic [MASK_W-1:0] rd,
                                       input logic [MASK_W-1:0] wr, input bit last);
        pass_in_t item;
        item.read_mask  = rd;
        item.write_mask = wr;
        item.last_pass  = last;
        pass_queue.insert(pass_queue.size(), item);
    endfunction

    // Acyclic frame: each resource has at most one writer; readers follow it until the shuffle.
    function automatic void queue_acyclic_frame(input int n);
        logic [MASK_W-1:0] rd [MAX_P];
        logic [MASK_W-1:0] wr [MAX_P];
        logic [MASK_W-1:0] claimed;
        logic [MASK_W-1:0] later;
        logic [MASK_W-1:0] tmp;
        int                j;
        claimed = '0;
        for (int t = 0; t < n; t++) begin
            wr[t]   = MASK_W'($urandom & $urandom) & ~claimed;
            claimed = claimed | wr[t];
        end
        later = '0;
        for (int t = n - 1; t >= 0; t--) begin
            rd[t] = MASK_W'($urandom) & ~later;
            later = later | wr[t];
        end
        // shuffle declaration order so the sort has work to do
        for (int i = n - 1; i > 0; i--) begin
            j     = $urandom_range(i);
            tmp   = rd[i];
            rd[i] = rd[j];
            rd[j] = tmp;
            tmp   = wr[i];
            wr[i] = wr[j];
            wr[j] = tmp;
        end
        for (int t = 0; t < n; t++) queue_pass(rd[t], wr[t], t == n - 1);
    endfunction

    function automatic void queue_noise_frame(input int n);
        for (int t = 0; t < n; t++)
            queue_pass(MASK_W'($urandom), MASK_W'($urandom), t == n - 1);
    endfunction

    function automatic int queue_random_frame();
        int n;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            n = $urandom_range(8, 1);
            queue_acyclic_frame(n);
        end else if (pick < 90) begin
            n = $urandom_range(8, 1);
            queue_noise_frame(n);
        end else begin
            n = $urandom_range(11, 9);
            queue_noise_frame(n);
        end
        return n;
    endfunction

    function automatic void queue_directed();
        // one pass touching everything, read then write of every resource
        queue_pass(8'hFF, 8'hFF, 1'b1);
        // empty pass
        queue_pass(8'h00, 8'h00, 1'b1);
        // consumer declared before its producer
        queue_pass(8'h01, 8'h00, 1'b0);
        queue_pass(8'h00, 8'h01, 1'b1);
        // two passes feeding each other
        queue_pass(8'h02, 8'h04, 1'b0);
        queue_pass(8'h04, 8'h02, 1'b1);
        // full frame as a reversed chain, order comes out 7 down to 0
        for (int k = 0; k < MAX_P; k++)
            queue_pass((k < MAX_P - 1) ? MASK_W'(1 << (k + 1)) : 8'h00,
                       MASK_W'(1 << k), k == MAX_P - 1);
        // one pass too many
        for (int k = 0; k <= MAX_P; k++) queue_pass(8'hAA, 8'h55, k == MAX_P);
    endfunction

    task automatic apply_kinds(input logic [KINDS_W-1:0] kinds);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= kinds;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        kinds_model = kinds;
    endtask

    task automatic drain_block();
        while (pass_queue.size() != 0 || s_valid || planned_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [KINDS_W-1:0] kinds, input int send_pct,
                             input int stall_pct, input bit pressure);
        int queued;
        apply_kinds(kinds);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (pressure) hold_request = 1'b1;
        queued = 0;
        while (queued < PHASE_ITEMS) queued += queue_random_frame();
        drain_block();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apply_kinds(16'hE4E4);
        queue_directed();
        drain_block();

        run_phase(KINDS_W'($urandom), 0, 0, 1'b0);
        run_phase(16'hFFFF, 50, 0, 1'b0);
        run_phase(16'h0000, 0, 50, 1'b0);
        run_phase(16'h5555, 33, 33, 1'b0);
        run_phase(16'hAAAA, 0, 0, 1'b1);
        run_phase(KINDS_W'($urandom), 33, 33, 1'b0);

        fail_count += planned_results.size();
        $display("covered %0d passes in %0d frames under seven kind settings",
                 passes_taken, frames_solved);
        $display("checked %0d results, %0d cycle errors, %0d overflow errors",
                 results_seen, cycle_errors, overflow_errs);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/pobp_pkg.sv
design/pobp_ctrl.sv
design/pobp_datapath.sv
design/pass_order_and_barrier_planner_core.sv
tb/tb_top.sv
